FILE: design/lhc_pkg.sv
package lhc_pkg;

    // FNV-1a
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;

    // Default depth of the hash queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Saturation / value mapping, Q0.16 (0.62 + 0.30*sb/255, 0.68 + 0.22*vb/255)
    localparam logic [15:0] S_BASE     = 16'd40632;
    localparam logic [23:0] S_SPAN     = 24'd19661;
    localparam logic [15:0] V_BASE     = 16'd44564;
    localparam logic [23:0] V_SPAN     = 24'd14418;
    localparam logic [23:0] RND_255    = 24'd127;
    localparam logic [31:0] RND_65535  = 32'd32767;

    // Tinted hue bands: floor on saturation, cap on value
    localparam logic [15:0] S_BAND_MIN = 16'd53739;
    localparam logic [15:0] V_BAND_MAX = 16'd48496;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL_SV,
        B_DIV_SV,
        B_CLAMP,
        B_MUL_C,
        B_DIV_C,
        B_FIX_C,
        B_MUL_X,
        B_DIV_X,
        B_EMIT
    } t_back_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] hash;
    } t_q_head;

    // floor(n/255) for n < 255*2^16: n*257/2^16 undershoots by under one, so one fixup
    function automatic logic [15:0] div255(input logic [23:0] n);
        logic [32:0] p;
        logic [16:0] q0;
        logic [24:0] prod;
        logic [24:0] rem;
        p    = {9'd0, n} + {1'b0, n, 8'd0};
        q0   = p[32:16];
        prod = {q0, 8'd0} - {8'd0, q0};
        rem  = {1'b0, n} - prod;
        if (rem >= 25'd255) begin
            q0 = q0 + 17'd1;
        end
        return q0[15:0];
    endfunction

endpackage

FILE: design/lhc_front.sv
module lhc_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_key_byte,
    input  logic        i_last_byte,
    output logic        o_push,
    output logic [31:0] o_push_hash,
    input  logic        i_q_full
);

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] mix;
    logic [31:0] folded;
    logic        accept;

    // prime = 2^24 + 0x193
    assign mix    = r_hash ^ {24'd0, i_key_byte};
    assign folded = mix + (mix << 1) + (mix << 4) + (mix << 7) + (mix << 8) + (mix << 24);

    assign o_stall     = i_q_full;
    assign accept      = i_valid && !i_q_full;
    assign o_push      = accept && i_last_byte;
    assign o_push_hash = folded;

    always_comb begin
        n_hash = r_hash;
        if (accept) begin
            n_hash = i_last_byte ? lhc_pkg::FNV_BASIS : folded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= lhc_pkg::FNV_BASIS;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

FILE: design/lhc_queue.sv
module lhc_queue #(
    parameter int DEPTH = lhc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [31:0]      i_push_hash,
    output logic             o_full,
    output lhc_pkg::t_q_head o_head,
    input  logic             i_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.hash  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: design/lhc_back.sv
module lhc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lhc_pkg::t_q_head i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [31:0]      o_key_hash,
    output logic [15:0]      o_red,
    output logic [15:0]      o_green,
    output logic [15:0]      o_blue
);

    lhc_pkg::t_back_state r_state;
    lhc_pkg::t_back_state n_state;

    logic [31:0] r_hash;
    logic [23:0] r_ns;
    logic [23:0] r_nv;
    logic        r_band;
    logic [2:0]  r_sector;
    logic [7:0]  r_w;
    logic [15:0] r_qs;
    logic [15:0] r_qv;
    logic [15:0] r_s;
    logic [15:0] r_v;
    logic [31:0] r_prod;
    logic [15:0] r_q0;
    logic [15:0] r_c;
    logic [23:0] r_nx;
    logic [15:0] r_x;

    logic        r_o_valid;
    logic [31:0] r_o_hash;
    logic [15:0] r_o_red;
    logic [15:0] r_o_green;
    logic [15:0] r_o_blue;

    logic        out_free;
    logic        load_out;

    // hue decode
    logic [7:0]  h8;
    logic [7:0]  hw;
    logic [10:0] t6;
    logic [2:0]  sector;
    logic [10:0] sec_base;
    logic [7:0]  rem;
    logic        band;

    // divide by 65535
    logic [47:0] sum48;
    logic [32:0] rem33;

    // clamp
    logic [15:0] s_raw;
    logic [15:0] v_raw;

    // channel build
    logic [15:0] m;
    logic [15:0] hi;
    logic [15:0] mid;
    logic [15:0] lo;

    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lhc_pkg::B_IDLE:   if (i_head.valid) n_state = lhc_pkg::B_MUL_SV;
            lhc_pkg::B_MUL_SV: n_state = lhc_pkg::B_DIV_SV;
            lhc_pkg::B_DIV_SV: n_state = lhc_pkg::B_CLAMP;
            lhc_pkg::B_CLAMP:  n_state = lhc_pkg::B_MUL_C;
            lhc_pkg::B_MUL_C:  n_state = lhc_pkg::B_DIV_C;
            lhc_pkg::B_DIV_C:  n_state = lhc_pkg::B_FIX_C;
            lhc_pkg::B_FIX_C:  n_state = lhc_pkg::B_MUL_X;
            lhc_pkg::B_MUL_X:  n_state = lhc_pkg::B_DIV_X;
            lhc_pkg::B_DIV_X:  n_state = lhc_pkg::B_EMIT;
            lhc_pkg::B_EMIT:   if (out_free) n_state = lhc_pkg::B_IDLE;
            default:           n_state = lhc_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            lhc_pkg::B_IDLE: o_pop    = i_head.valid;
            lhc_pkg::B_EMIT: load_out = out_free;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // sector = floor(6*h/255), with full hue wrapping to zero
    always_comb begin
        h8   = r_hash[7:0];
        hw   = (h8 == 8'd255) ? 8'd0 : h8;
        t6   = {1'b0, hw, 2'b00} + {2'b00, hw, 1'b0};
        band = h8 inside {[8'd0:8'd5], [8'd29:8'd51], [8'd220:8'd255]};
        if (t6 >= 11'd1275) begin
            sector = 3'd5;
        end else if (t6 >= 11'd1020) begin
            sector = 3'd4;
        end else if (t6 >= 11'd765) begin
            sector = 3'd3;
        end else if (t6 >= 11'd510) begin
            sector = 3'd2;
        end else if (t6 >= 11'd255) begin
            sector = 3'd1;
        end else begin
            sector = 3'd0;
        end
        sec_base = {sector, 8'd0} - {8'd0, sector};
        rem      = 8'(t6 - sec_base);
    end

    assign sum48 = {16'd0, r_prod} + {r_prod, 16'd0};
    assign rem33 = {1'b0, r_prod} + {17'd0, r_q0} - {1'b0, r_q0, 16'd0};

    always_comb begin
        s_raw = lhc_pkg::S_BASE + r_qs;
        v_raw = lhc_pkg::V_BASE + r_qv;
        if (r_band && s_raw < lhc_pkg::S_BAND_MIN) begin
            s_raw = lhc_pkg::S_BAND_MIN;
        end
        if (r_band && v_raw > lhc_pkg::V_BAND_MAX) begin
            v_raw = lhc_pkg::V_BAND_MAX;
        end
    end

    assign m   = r_v - r_c;
    assign hi  = r_v;
    assign mid = r_x + m;
    assign lo  = m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lhc_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lhc_pkg::B_IDLE: begin
                r_hash <= i_head.hash;
            end
            lhc_pkg::B_MUL_SV: begin
                r_ns     <= lhc_pkg::S_SPAN * {16'd0, r_hash[15:8]} + lhc_pkg::RND_255;
                r_nv     <= lhc_pkg::V_SPAN * {16'd0, r_hash[23:16]} + lhc_pkg::RND_255;
                r_band   <= band;
                r_sector <= sector;
                r_w      <= sector[0] ? 8'd255 - rem : rem;
            end
            lhc_pkg::B_DIV_SV: begin
                r_qs <= lhc_pkg::div255(r_ns);
                r_qv <= lhc_pkg::div255(r_nv);
            end
            lhc_pkg::B_CLAMP: begin
                r_s <= s_raw;
                r_v <= v_raw;
            end
            lhc_pkg::B_MUL_C: begin
                r_prod <= {16'd0, r_v} * {16'd0, r_s} + lhc_pkg::RND_65535;
            end
            lhc_pkg::B_DIV_C: begin
                r_q0 <= sum48[47:32];
            end
            lhc_pkg::B_FIX_C: begin
                r_c <= (rem33 >= 33'd65535) ? r_q0 + 16'd1 : r_q0;
            end
            lhc_pkg::B_MUL_X: begin
                r_nx <= {8'd0, r_c} * {16'd0, r_w} + lhc_pkg::RND_255;
            end
            lhc_pkg::B_DIV_X: begin
                r_x <= lhc_pkg::div255(r_nx);
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_hash <= r_hash;
            case (r_sector)
                3'd0: begin r_o_red <= hi;  r_o_green <= mid; r_o_blue <= lo;  end
                3'd1: begin r_o_red <= mid; r_o_green <= hi;  r_o_blue <= lo;  end
                3'd2: begin r_o_red <= lo;  r_o_green <= hi;  r_o_blue <= mid; end
                3'd3: begin r_o_red <= lo;  r_o_green <= mid; r_o_blue <= hi;  end
                3'd4: begin r_o_red <= mid; r_o_green <= lo;  r_o_blue <= hi;  end
                default: begin r_o_red <= hi; r_o_green <= lo; r_o_blue <= mid; end
            endcase
        end
    end

    assign o_valid    = r_o_valid;
    assign o_key_hash = r_o_hash;
    assign o_red      = r_o_red;
    assign o_green    = r_o_green;
    assign o_blue     = r_o_blue;

endmodule

FILE: design/label_hash_color_top.sv
// Channel   | Direction | Handshake           | Beat payload
// ----------+-----------+---------------------+-------------------------------------
// key in    | in        | i_valid / o_stall   | i_key_byte, i_last_byte
// color out | out       | o_valid / i_stall   | o_key_hash, o_red, o_green, o_blue
//
// Key bytes are taken one per cycle while o_stall is low; the FNV-1a fold is a
// shift-add of the running hash. Each finished hash goes through a short queue to the
// color sequencer, which per key does a pop, eight arithmetic steps and an output load
// before taking the next; keys that come faster fill the queue and then see o_stall.
// Reset is synchronous, active low; the running hash returns to the offset basis.
// i_stall holds the output register; the sequencer waits in its last step meanwhile.
module label_hash_color_top #(
    parameter int QUEUE_DEPTH = lhc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_key_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_key_hash,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue
);

    // front -> queue
    logic        push;
    logic [31:0] push_hash;
    logic        q_full;

    // queue -> back
    lhc_pkg::t_q_head q_head;
    logic             pop;

    // Front: folds each byte into the running hash, pushes the hash on the last byte.
    lhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_key_byte  (i_key_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_push_hash (push_hash),
        .i_q_full    (q_full)
    );

    // Finished hashes waiting for the color sequencer.
    lhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_hash (push_hash),
        .o_full      (q_full),
        .o_head      (q_head),
        .i_pop       (pop)
    );

    // Back: hash -> HSV -> RGB, one step per cycle unless i_stall holds the output, into the output register.
    lhc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_key_hash (o_key_hash),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

endmodule

FILE: design/lhc_checker.sv
module lhc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_key_hash,
    input logic [15:0] o_red,
    input logic [15:0] o_green,
    input logic [15:0] o_blue
);

    // brightest channel is v (>= 0.68); darkest is v*(1-s) (<= 0.38*0.90)
    localparam logic [15:0] MAX_CH_LOW  = 16'd44564;
    localparam logic [15:0] MIN_CH_HIGH = 16'd22500;

    // held beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_key_hash) && $stable(o_red)
            && $stable(o_green) && $stable(o_blue))
        else $error("output beat changed while stalled");

    // no result right out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red >= MAX_CH_LOW) || (o_green >= MAX_CH_LOW) || (o_blue >= MAX_CH_LOW))
        else $error("no channel reaches the value floor");

    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red <= MIN_CH_HIGH) || (o_green <= MIN_CH_HIGH)
            || (o_blue <= MIN_CH_HIGH))
        else $error("no channel at the saturated floor");

endmodule

bind label_hash_color_top lhc_checker u_lhc_checker (.*);
